[rtl/baro_altitude_pairing_table_macros.svh]
`ifndef BARO_ALTITUDE_PAIRING_TABLE_MACROS_SVH
`define BARO_ALTITUDE_PAIRING_TABLE_MACROS_SVH
// implication checked on every clock edge outside reset
`define BAPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define BAPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/bapt_pkg.sv]
package bapt_pkg;
  localparam int TableDepth = 512;
  localparam int LevelOffset = 33;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CmPerLevel = 3048;

  localparam logic [1:0] OP_GEO = 2'd0;
  localparam logic [1:0] OP_PRESS = 2'd1;
  localparam logic [1:0] OP_SWEEP = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [2:0] REG_WINDOW = 3'd0;
  localparam logic [2:0] REG_MAX_AGE = 3'd1;
  localparam logic [2:0] REG_MATCH = 3'd2;
  localparam logic [2:0] REG_MIN_ALT = 3'd3;
  localparam logic [2:0] REG_MAX_ALT = 3'd4;

  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_STORE = 3'd1;
  localparam logic [2:0] CMD_SWEEP = 3'd2;
  localparam logic [2:0] CMD_QUERY = 3'd3;
  localparam logic [2:0] CMD_QNONE = 3'd4;

  typedef struct packed {
    logic [2:0] cmd;
    logic [IdxW-1:0] idx;
    logic signed [20:0] geo;
    logic signed [20:0] press;
    logic [31:0] stamp;
  } cmd_t;
endpackage

[rtl/baro_altitude_pairing_table.sv]
// Barometric altitude pairing table.
// Input channel (in_valid/in_stall): op, altitude_cm, altitude_finite, now_s.
//   op 0/1 are geometric/pressure samples, 2 an age sweep, 3 a query.
// Result channel (out_valid/out_stall): exactly one result per request.
// Configuration: cfg_we, cfg_index, cfg_wdata; written only while idle, which the user must ensure.
// A front end keeps the pending samples and turns a pair into a flight-level
// index by a constant reciprocal multiply; a one-entry queue hands commands
// to the back end, which owns the 512-entry table RAM with its valid flags.
// Rejected samples pass the queue and the result register; unpaired samples
// pass S_PAIR first, pairs S_PAIR and S_DIV; sweeps and queries scan the
// table in B_SCAN and B_LAST (one RAM read a cycle). While a scan holds the
// back end, the front queues one more request and stalls until it is popped.
// Reset restores the registers and clears the pending samples; the back end
// then runs a clearing pass over all 512 table entries before it takes work.
// When out_stall is high the result holds and the back end waits; the front
// keeps accepting until the queue fills.
module baro_altitude_pairing_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic signed [20:0]   in_altitude_cm,
  input  logic                 in_altitude_finite,
  input  logic [31:0]          in_now_s,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_estimate_valid,
  output logic signed [21:0]   out_estimated_pressure_cm,
  output logic                 out_pair_stored,
  output logic [9:0]           out_removed_count,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [20:0]          cfg_wdata
);
  import bapt_pkg::*;
  logic [7:0] win_r;
  logic [15:0] age_r;
  logic [19:0] lim_r;
  logic signed [20:0] min_r, max_r;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= 8'd3;
      age_r <= 16'd2400;
      lim_r <= 20'd15240;
      min_r <= -21'sd100000;
      max_r <= 21'sd1000000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW: win_r <= cfg_wdata[7:0];
        REG_MAX_AGE: age_r <= cfg_wdata[15:0];
        REG_MATCH: lim_r <= cfg_wdata[19:0];
        REG_MIN_ALT: min_r <= cfg_wdata;
        REG_MAX_ALT: max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bapt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_altitude_cm(in_altitude_cm),
    .in_altitude_finite(in_altitude_finite), .in_now_s(in_now_s),
    .win_s(win_r), .min_alt(min_r), .max_alt(max_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  bapt_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .max_age(age_r), .match_lim(lim_r),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_estimate_valid(out_estimate_valid),
    .out_estimated_pressure_cm(out_estimated_pressure_cm),
    .out_pair_stored(out_pair_stored), .out_removed_count(out_removed_count)
  );
endmodule

[rtl/bapt_ram.sv]
module bapt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/bapt_front.sv]
module bapt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic signed [20:0]   in_altitude_cm,
  input  logic                 in_altitude_finite,
  input  logic [31:0]          in_now_s,
  input  logic [7:0]           win_s,
  input  logic signed [20:0]   min_alt,
  input  logic signed [20:0]   max_alt,
  output logic                 q_valid,
  input  logic                 q_pop,
  output bapt_pkg::cmd_t       q_cmd
);
  import bapt_pkg::*;
  // single-entry queue plus the level-computation states S_PAIR and S_DIV
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_PAIR = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic pg_v_r, pp_v_r;
  logic signed [20:0] pg_alt_r, pp_alt_r;
  logic [31:0] pg_t_r, pp_t_r;
  logic qv_r;
  cmd_t qc_r;
  logic [21:0] rem_r;
  logic [35:0] prod;
  logic [9:0] quo;
  logic [31:0] gap;
  logic acc, ok, is_sample, pairable;
  logic [21:0] num;
  logic signed [11:0] lvl;
  logic signed [12:0] idx_full;

  assign in_stall = qv_r || (st_r != S_IDLE);
  assign acc = in_valid && !in_stall;
  assign is_sample = (in_op == OP_GEO) || (in_op == OP_PRESS);
  assign ok = in_altitude_finite && (in_altitude_cm >= min_alt)
              && (in_altitude_cm <= max_alt);
  assign q_valid = qv_r;
  assign q_cmd = qc_r;
  assign gap = (pg_t_r >= pp_t_r) ? pg_t_r - pp_t_r : pp_t_r - pg_t_r;
  assign pairable = pg_v_r && pp_v_r && gap <= 32'(win_s);
  assign num = pp_alt_r[20] ? 22'(-{pp_alt_r[20], pp_alt_r}) : 22'({1'b0, pp_alt_r});
  // x / 6096 as ((x >> 4) * ceil(2^26 / 381)) >> 26, exact for x < 2^22
  assign prod = 36'(rem_r[21:4]) * 36'd176139;
  assign quo = prod[35:26];
  assign lvl = pp_alt_r[20] ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
  assign idx_full = 13'(lvl) + 13'(LevelOffset);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (acc && is_sample && ok) st_nxt = S_PAIR;
      S_PAIR: st_nxt = pairable ? S_DIV : S_IDLE;
      S_DIV: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pg_v_r <= 1'b0;
      pp_v_r <= 1'b0;
      qv_r <= 1'b0;
      pg_alt_r <= '0;
      pp_alt_r <= '0;
      pg_t_r <= '0;
      pp_t_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (q_pop) qv_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (acc) begin
            if (is_sample) begin
              if (ok) begin
                if (in_op == OP_GEO) begin
                  pg_v_r <= 1'b1; pg_alt_r <= in_altitude_cm; pg_t_r <= in_now_s;
                end else begin
                  pp_v_r <= 1'b1; pp_alt_r <= in_altitude_cm; pp_t_r <= in_now_s;
                end
              end else begin
                qv_r <= 1'b1;
                qc_r.cmd <= CMD_NONE;
              end
            end else begin
              qv_r <= 1'b1;
              qc_r.cmd <= (in_op == OP_SWEEP) ? CMD_SWEEP :
                          (in_altitude_finite ? CMD_QUERY : CMD_QNONE);
              qc_r.geo <= in_altitude_cm;
              qc_r.stamp <= in_now_s;
            end
          end
        end
        S_PAIR: begin
          // 2 * |pressure| + 3048, divided by 6096 in the next cycle
          rem_r <= {num[20:0], 1'b0} + 22'(CmPerLevel);
          if (!pairable) begin
            qv_r <= 1'b1;
            qc_r.cmd <= CMD_NONE;
          end
        end
        S_DIV: begin
          qv_r <= 1'b1;
          qc_r.cmd <= (idx_full >= 0 && idx_full < 13'(TableDepth)) ? CMD_STORE : CMD_NONE;
          qc_r.idx <= IdxW'(idx_full);
          qc_r.geo <= pg_alt_r;
          qc_r.press <= pp_alt_r;
          qc_r.stamp <= pp_t_r;
          pg_v_r <= 1'b0; pp_v_r <= 1'b0;
          pg_alt_r <= '0; pp_alt_r <= '0; pg_t_r <= '0; pp_t_r <= '0;
        end
        default: ;
      endcase
    end
  end

`include "baro_altitude_pairing_table_macros.svh"
  `BAPT_ASSERT_IMP(a_stall_busy, st_r != S_IDLE, in_stall, "front accepted while busy")
  `BAPT_ASSERT_NXT(a_pair_clears, st_r == S_DIV, !pg_v_r && !pp_v_r && qv_r, "pair not cleared")
  `BAPT_ASSERT_IMP(a_queue_busy, qv_r, st_r == S_IDLE, "queue full during pairing")
endmodule

[rtl/bapt_back.sv]
module bapt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  bapt_pkg::cmd_t       q_cmd,
  input  logic [15:0]          max_age,
  input  logic [19:0]          match_lim,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_estimate_valid,
  output logic signed [21:0]   out_estimated_pressure_cm,
  output logic                 out_pair_stored,
  output logic [9:0]           out_removed_count
);
  import bapt_pkg::*;
  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SCAN = 2'd1;
  localparam logic [1:0] B_LAST = 2'd2;
  localparam logic [1:0] B_CLR = 2'd3;

  logic [1:0] st_r;
  logic [IdxW-1:0] cnt_r;
  logic [IdxW-1:0] prev_r;
  logic scan_v_r, is_sweep_r;
  logic signed [20:0] qalt_r;
  logic [31:0] now_r;
  logic [9:0] rem_cnt_r;
  logic best_v_r;
  logic [21:0] bestd_r;
  logic signed [20:0] bgeo_r, bpress_r;
  logic ov_r;

  logic we, take, do_store, drop, ov_set;
  logic [IdxW-1:0] raddr, waddr;
  logic [74:0] rdata, wdata;
  logic rvalid;
  logic signed [20:0] rgeo, rpress;
  logic [31:0] rstamp;
  logic signed [22:0] diff;
  logic [21:0] gdist;
  logic old, last_better, hit;
  logic [21:0] fdist;
  logic signed [20:0] egeo, epress;
  logic signed [23:0] est;
  logic signed [21:0] est_sat;

  assign take = q_valid && st_r == B_IDLE && !(out_valid && out_stall);
  assign q_pop = take;
  assign do_store = take && q_cmd.cmd == CMD_STORE;
  assign drop = scan_v_r && is_sweep_r && rvalid && old;
  // the valid flag lives in the RAM word: clearing pass, stores and sweep deletes
  assign we = (st_r == B_CLR) || do_store || drop;
  assign waddr = (st_r == B_CLR) ? cnt_r : (do_store ? q_cmd.idx : prev_r);
  assign wdata = do_store ? {1'b1, q_cmd.geo, q_cmd.press, q_cmd.stamp} : '0;
  assign raddr = cnt_r;
  assign {rvalid, rgeo, rpress, rstamp} = rdata;
  assign diff = 23'(rgeo) - 23'(qalt_r);
  assign gdist = diff[22] ? 22'(-diff) : 22'(diff);
  assign old = ({1'b0, now_r} - {1'b0, rstamp}) > 33'(max_age) && now_r >= rstamp;
  assign last_better = rvalid && (!best_v_r || gdist < bestd_r);
  assign fdist = last_better ? gdist : bestd_r;
  assign hit = (last_better || best_v_r) && fdist <= 22'(match_lim);
  assign egeo = last_better ? rgeo : bgeo_r;
  assign epress = last_better ? rpress : bpress_r;
  assign est = 24'(epress) - 24'(egeo) + 24'(qalt_r);
  assign est_sat = est > 24'sd2097151 ? 22'sh1FFFFF :
                   est < -24'sd2097152 ? 22'sh200000 : 22'(est);
  assign ov_set = (st_r == B_LAST) ||
                  (take && q_cmd.cmd != CMD_SWEEP && q_cmd.cmd != CMD_QUERY);

  bapt_ram #(.Width(75), .Depth(TableDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_CLR;
      cnt_r <= '0;
      ov_r <= 1'b0;
      scan_v_r <= 1'b0;
    end else begin
      scan_v_r <= st_r == B_SCAN;
      if (ov_set) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
      case (st_r)
        B_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == IdxW'(TableDepth - 1)) st_r <= B_IDLE;
        end
        B_IDLE: begin
          if (take) begin
            out_estimate_valid <= 1'b0;
            out_estimated_pressure_cm <= '0;
            out_pair_stored <= 1'b0;
            out_removed_count <= '0;
            if (q_cmd.cmd == CMD_SWEEP || q_cmd.cmd == CMD_QUERY) begin
              st_r <= B_SCAN;
              cnt_r <= '0;
              is_sweep_r <= q_cmd.cmd == CMD_SWEEP;
              qalt_r <= q_cmd.geo;
              now_r <= q_cmd.stamp;
              rem_cnt_r <= '0;
              best_v_r <= 1'b0;
            end else if (do_store) begin
              out_pair_stored <= 1'b1;
            end
          end
        end
        B_SCAN: begin
          prev_r <= raddr;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == IdxW'(TableDepth - 1)) st_r <= B_LAST;
        end
        B_LAST: begin
          st_r <= B_IDLE;
          if (is_sweep_r) begin
            out_removed_count <= rem_cnt_r + (drop ? 10'd1 : 10'd0);
          end else begin
            out_estimate_valid <= hit;
            out_estimated_pressure_cm <= hit ? est_sat : '0;
          end
        end
        default: st_r <= B_IDLE;
      endcase
      if (scan_v_r && st_r != B_LAST && rvalid) begin
        if (is_sweep_r) begin
          if (old) rem_cnt_r <= rem_cnt_r + 10'd1;
        end else if (!best_v_r || gdist < bestd_r) begin
          best_v_r <= 1'b1;
          bestd_r <= gdist;
          bgeo_r <= rgeo;
          bpress_r <= rpress;
        end
      end
    end
  end

`include "baro_altitude_pairing_table_macros.svh"
  `BAPT_ASSERT_IMP(a_no_pop_busy, st_r != B_IDLE, !q_pop, "pop during scan")
  `BAPT_ASSERT_NXT(a_last_outputs, st_r == B_LAST, out_valid, "no result after scan")
  `BAPT_ASSERT_IMP(a_store_flag, out_valid && out_pair_stored, !out_estimate_valid && out_removed_count == '0, "mixed result")
endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import bapt_pkg::*;

  typedef struct {
    logic               est_valid;
    logic signed [21:0] est_cm;
    logic               stored;
    logic [9:0]         removed;
  } result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_op;
  logic signed [20:0] in_altitude_cm;
  logic in_altitude_finite;
  logic [31:0] in_now_s;
  logic out_valid;
  logic out_stall;
  logic out_estimate_valid;
  logic signed [21:0] out_estimated_pressure_cm;
  logic out_pair_stored;
  logic [9:0] out_removed_count;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [20:0] cfg_wdata;

  baro_altitude_pairing_table i_dut (.*);

  // predictor state
  logic [7:0] win_s;
  logic [15:0] age_s;
  logic [19:0] limit_cm;
  logic signed [20:0] lo_cm, hi_cm;
  logic geo_ok, press_ok;
  logic signed [20:0] geo_alt, press_alt;
  logic [31:0] geo_t, press_t;
  logic tbl_valid [TableDepth];
  logic signed [20:0] tbl_geo [TableDepth];
  logic signed [20:0] tbl_press [TableDepth];
  logic [31:0] tbl_stamp [TableDepth];

  result_t expected_q[$];
  int mismatches;
  int idle_pct;
  logic [31:0] clock_s;
  int cycles;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 6000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int level_index(logic signed [20:0] p);
    longint a, q;
    a = p < 0 ? -longint'(p) : longint'(p);
    q = (2 * a + CmPerLevel) / (2 * CmPerLevel);
    return int'(p < 0 ? -q : q) + LevelOffset;
  endfunction

  function automatic logic try_pairing();
    longint gap;
    int idx;
    logic ok;
    ok = 0;
    if (!geo_ok || !press_ok) return 0;
    gap = longint'(geo_t) - longint'(press_t);
    if (gap < 0) gap = -gap;
    if (gap > longint'(win_s)) return 0;
    idx = level_index(press_alt);
    if (idx >= 0 && idx < TableDepth) begin
      tbl_valid[idx] = 1;
      tbl_geo[idx] = geo_alt;
      tbl_press[idx] = press_alt;
      tbl_stamp[idx] = press_t;
      ok = 1;
    end
    geo_ok = 0; press_ok = 0;
    geo_alt = 0; press_alt = 0; geo_t = 0; press_t = 0;
    return ok;
  endfunction

  function automatic result_t predict_table(logic [1:0] op, logic signed [20:0] alt,
                                            logic fin, logic [31:0] now);
    result_t r;
    int n, best;
    longint d, bestd, e;
    r = '{0, 0, 0, 0};
    n = 0; best = -1; bestd = 0;
    if (op == OP_GEO || op == OP_PRESS) begin
      if (fin && alt >= lo_cm && alt <= hi_cm) begin
        if (op == OP_GEO) begin
          geo_ok = 1; geo_alt = alt; geo_t = now;
        end else begin
          press_ok = 1; press_alt = alt; press_t = now;
        end
        r.stored = try_pairing();
      end
    end else if (op == OP_SWEEP) begin
      for (int i = 0; i < TableDepth; i++)
        if (tbl_valid[i] && longint'(now) - longint'(tbl_stamp[i]) > longint'(age_s)) begin
          tbl_valid[i] = 0;
          n++;
        end
      r.removed = n[9:0];
    end else if (fin) begin
      for (int i = 0; i < TableDepth; i++) begin
        if (!tbl_valid[i]) continue;
        d = longint'(tbl_geo[i]) - longint'(alt);
        if (d < 0) d = -d;
        if (best < 0 || d < bestd) begin
          best = i; bestd = d;
        end
      end
      if (best >= 0 && bestd <= longint'(limit_cm)) begin
        e = longint'(tbl_press[best]) - longint'(tbl_geo[best]) + longint'(alt);
        if (e > 2097151) e = 2097151;
        if (e < -2097152) e = -2097152;
        r.est_valid = 1;
        r.est_cm = e[21:0];
      end
    end
    return r;
  endfunction

  task automatic send_request(logic [1:0] op, logic signed [20:0] alt, logic fin,
                              logic [31:0] now);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_altitude_cm <= alt;
    in_altitude_finite <= fin;
    in_now_s <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q = {expected_q, predict_table(op, alt, fin, now)};
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [20:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_WINDOW: win_s = val[7:0];
      REG_MAX_AGE: age_s = val[15:0];
      REG_MATCH: limit_cm = val[19:0];
      REG_MIN_ALT: lo_cm = val;
      REG_MAX_ALT: hi_cm = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_estimate_valid !== exp_r.est_valid || out_estimated_pressure_cm !== exp_r.est_cm
            || out_pair_stored !== exp_r.stored || out_removed_count !== exp_r.removed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0b %0d %0b %0d got %0b %0d %0b %0d",
                     exp_r.est_valid, exp_r.est_cm, exp_r.stored, exp_r.removed,
                     out_estimate_valid, out_estimated_pressure_cm, out_pair_stored,
                     out_removed_count);
        end
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < idle_pct);

  task automatic test_directed();
    send_request(OP_QUERY, 0, 1, 0);
    send_request(OP_GEO, 21'sd100000, 1, 10);
    send_request(OP_PRESS, 21'sd101524, 1, 12);
    send_request(OP_GEO, 21'sd200000, 0, 13);
    send_request(OP_GEO, -21'sd100001, 1, 13);
    send_request(OP_PRESS, 21'sd1000001, 1, 13);
    send_request(OP_GEO, 21'sd1524, 1, 20);
    send_request(OP_PRESS, 21'sd1524, 1, 30);
    send_request(OP_PRESS, 21'sd1524, 1, 21);
    send_request(OP_GEO, -21'sd100000, 1, 22);
    send_request(OP_PRESS, -21'sd100000, 1, 22);
    send_request(OP_GEO, 21'sd1000000, 1, 23);
    send_request(OP_PRESS, 21'sd1000000, 1, 23);
    send_request(OP_GEO, 21'sd50000, 1, 24);
    send_request(OP_PRESS, -21'sd1524, 1, 24);
    send_request(OP_QUERY, 21'sd100000, 1, 25);
    send_request(OP_QUERY, 21'sd1048575, 1, 25);
    send_request(OP_QUERY, -21'sd1048576, 1, 25);
    send_request(OP_QUERY, 21'sd1000, 0, 25);
    send_request(OP_SWEEP, 0, 1, 20);
    send_request(OP_SWEEP, 0, 1, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_saturation();
    write_reg(REG_WINDOW, 8'd255);
    write_reg(REG_MATCH, 21'hFFFFF);
    write_reg(REG_MAX_AGE, 16'hFFFF);
    write_reg(REG_MIN_ALT, -21'sd100000);
    write_reg(REG_MAX_ALT, 21'sd1000000);
    write_reg(3'd7, 21'h1FFFFF);
    send_request(OP_GEO, -21'sd100000, 1, 100);
    send_request(OP_PRESS, 21'sd1000000, 1, 355);
    send_request(OP_QUERY, 21'sd1048575, 1, 355);
    send_request(OP_GEO, 21'sd1000000, 1, 356);
    send_request(OP_PRESS, -21'sd100000, 1, 356);
    send_request(OP_QUERY, -21'sd1048576, 1, 356);
    send_request(OP_SWEEP, 0, 1, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic random_phase(int count);
    int k;
    logic signed [20:0] g;
    for (k = 0; k < count; k++) begin
      clock_s = clock_s + $urandom_range(3);
      g = $signed(21'($urandom_range(1100000))) - 21'sd100000;
      case ($urandom_range(9))
        0: send_request(2'($urandom), 21'($urandom), 1'($urandom), $urandom);
        1: send_request(OP_SWEEP, 21'($urandom), 1'($urandom), clock_s);
        2, 3: send_request(OP_QUERY, g + 21'($urandom_range(40000)) - 21'sd20000,
                           $urandom_range(15) != 0, clock_s);
        default: begin
          send_request(OP_GEO, g, $urandom_range(19) != 0, clock_s);
          send_request(OP_PRESS, g + 21'($urandom_range(60000)) - 21'sd30000,
                       $urandom_range(19) != 0, clock_s + $urandom_range(4));
          k++;
        end
      endcase
    end
    drain();
  endtask

  task automatic test_random();
    idle_pct = 37;
    random_phase(200);
    write_reg(REG_WINDOW, 8'd0);
    write_reg(REG_MAX_AGE, 16'd0);
    write_reg(REG_MATCH, 20'd0);
    write_reg(REG_MIN_ALT, 21'sd0);
    write_reg(REG_MAX_ALT, 21'sd500000);
    random_phase(150);
    idle_pct = 0;
    random_phase(100);
    idle_pct = 37;
    write_reg(REG_WINDOW, 8'd3);
    write_reg(REG_MAX_AGE, 16'd40);
    write_reg(REG_MATCH, 20'd15240);
    write_reg(REG_MIN_ALT, -21'sd100000);
    write_reg(REG_MAX_ALT, 21'sd1000000);
    random_phase(200);
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_op = OP_GEO; in_altitude_cm = 0;
    in_altitude_finite = 0; in_now_s = 0; out_stall = 0;
    cfg_we = 0; cfg_index = REG_WINDOW; cfg_wdata = 0;
    cycles = 0; mismatches = 0; idle_pct = 37; clock_s = 1000;
    win_s = 3; age_s = 2400; limit_cm = 15240; lo_cm = -100000; hi_cm = 1000000;
    geo_ok = 0; press_ok = 0; geo_alt = 0; press_alt = 0; geo_t = 0; press_t = 0;
    for (int i = 0; i < TableDepth; i++) tbl_valid[i] = 0;
    repeat (7) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    test_directed();
    test_saturation();
    test_random();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/bapt_pkg.sv
rtl/bapt_ram.sv
rtl/bapt_front.sv
rtl/bapt_back.sv
rtl/baro_altitude_pairing_table.sv
tb/testbench.sv
